// File: rtl/eul_pkg.sv
package eul_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int OUT_FRAC_BITS   = 14;
  localparam int STEPS           = 30;
  localparam int XW              = 34;
  localparam int ZW              = 35;
  localparam int PW              = 2 * XW;
  localparam int LATENCY         = STEPS + 4;
  localparam int OUT_LIM         = (OUT_FRAC_BITS >= 15) ? 32767 : (1 << OUT_FRAC_BITS);

  localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = ZW'(64'sd6746518852);
  localparam logic signed [XW-1:0] K_Q30       = XW'(64'sd652032874);

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } lane_t;

  function automatic longint atan_q30(int i);
    longint r;
    case (i)
      0:       r = 64'sd843314857;
      1:       r = 64'sd497837829;
      2:       r = 64'sd263043837;
      3:       r = 64'sd133525159;
      4:       r = 64'sd67021687;
      5:       r = 64'sd33543516;
      6:       r = 64'sd16775851;
      7:       r = 64'sd8388437;
      8:       r = 64'sd4194283;
      9:       r = 64'sd2097149;
      10:      r = 64'sd1048576;
      default: r = 64'sd1 <<< (30 - i);
    endcase
    return r;
  endfunction

endpackage

// File: rtl/eul_prep.sv
module eul_prep (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic signed [15:0]    angle_i [3],
  output logic                  valid_o,
  output eul_pkg::lane_t [2:0]  lane_o
);

  localparam int SH = 30 - eul_pkg::ANGLE_FRAC_BITS;

  eul_pkg::lane_t [2:0] lane_d, lane_q;
  logic                 valid_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic signed [eul_pkg::ZW-1:0] z;
      logic                          neg;
      z = eul_pkg::ZW'(angle_i[j]) <<< SH;
      if (z > eul_pkg::PI_Q30) begin
        z = z - eul_pkg::TWO_PI_Q30;
      end
      if (z < -eul_pkg::PI_Q30) begin
        z = z + eul_pkg::TWO_PI_Q30;
      end
      neg = 1'b0;
      if (z > eul_pkg::HALF_PI_Q30) begin
        z   = z - eul_pkg::PI_Q30;
        neg = 1'b1;
      end else if (z < -eul_pkg::HALF_PI_Q30) begin
        z   = z + eul_pkg::PI_Q30;
        neg = 1'b1;
      end
      lane_d[j].x   = eul_pkg::K_Q30;
      lane_d[j].y   = '0;
      lane_d[j].z   = z;
      lane_d[j].neg = neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

// File: rtl/eul_cell.sv
module eul_cell #(
  parameter int IDX = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  eul_pkg::lane_t [2:0]  lane_i,
  output logic                  valid_o,
  output eul_pkg::lane_t [2:0]  lane_o
);

  localparam logic signed [eul_pkg::ZW-1:0] ATAN = eul_pkg::ZW'(eul_pkg::atan_q30(IDX));

  eul_pkg::lane_t [2:0] lane_d, lane_q;
  logic                 valid_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic signed [eul_pkg::XW-1:0] dx;
      logic signed [eul_pkg::XW-1:0] dy;
      dx = lane_i[j].y >>> IDX;
      dy = lane_i[j].x >>> IDX;
      lane_d[j].neg = lane_i[j].neg;
      if (!lane_i[j].z[eul_pkg::ZW-1]) begin
        lane_d[j].x = lane_i[j].x - dx;
        lane_d[j].y = lane_i[j].y + dy;
        lane_d[j].z = lane_i[j].z - ATAN;
      end else begin
        lane_d[j].x = lane_i[j].x + dx;
        lane_d[j].y = lane_i[j].y - dy;
        lane_d[j].z = lane_i[j].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

// File: rtl/eul_mat.sv
module eul_mat (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  eul_pkg::lane_t [2:0]  lane_i,
  output logic                  valid_o,
  output logic signed [15:0]    m_o [9]
);

  localparam int XW = eul_pkg::XW;
  localparam int PW = eul_pkg::PW;
  localparam int S  = 60 - eul_pkg::OUT_FRAC_BITS;
  localparam logic signed [PW-1:0] LIM  = PW'(eul_pkg::OUT_LIM);
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (S - 1);
  localparam logic signed [PW-1:0] RND  = PW'(1) <<< 29;

  function automatic logic signed [15:0] emit(logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = (v + HALF) >>> S;
    if (r > LIM) begin
      r = LIM;
    end
    if (r < -LIM) begin
      r = -LIM;
    end
    return r[15:0];
  endfunction

  logic signed [XW-1:0] s [3];
  logic signed [XW-1:0] c [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s[j] = lane_i[j].neg ? -lane_i[j].y : lane_i[j].y;
      c[j] = lane_i[j].neg ? -lane_i[j].x : lane_i[j].x;
    end
  end

  // first product stage
  logic signed [PW-1:0] czsy_q, szsy_q, p00_q, p10_q, p21_q, p22_q;
  logic signed [PW-1:0] szcx_q, szsx_q, czcx_q, czsx_q;
  logic signed [XW-1:0] sx_q, cx_q, sy_q;
  logic [2:0]           v_q;

  always_ff @(posedge clk_i) begin
    czsy_q <= c[2] * s[1];
    szsy_q <= s[2] * s[1];
    p00_q  <= c[2] * c[1];
    p10_q  <= s[2] * c[1];
    p21_q  <= c[1] * s[0];
    p22_q  <= c[1] * c[0];
    szcx_q <= s[2] * c[0];
    szsx_q <= s[2] * s[0];
    czcx_q <= c[2] * c[0];
    czsx_q <= c[2] * s[0];
    sx_q   <= s[0];
    cx_q   <= c[0];
    sy_q   <= s[1];
  end

  // triple products; the other entries pass through
  logic signed [XW-1:0] czsy, szsy;
  logic signed [PW-1:0] sum_q [9];
  logic signed [PW-1:0] czsy_r, szsy_r;

  assign czsy_r = (czsy_q + RND) >>> 30;
  assign szsy_r = (szsy_q + RND) >>> 30;
  assign czsy   = czsy_r[XW-1:0];
  assign szsy   = szsy_r[XW-1:0];

  always_ff @(posedge clk_i) begin
    sum_q[0] <= p00_q;
    sum_q[1] <= czsy * sx_q - szcx_q;
    sum_q[2] <= czsy * cx_q + szsx_q;
    sum_q[3] <= p10_q;
    sum_q[4] <= szsy * sx_q + czcx_q;
    sum_q[5] <= szsy * cx_q - czsx_q;
    sum_q[6] <= -(PW'(sy_q) <<< 30);
    sum_q[7] <= p21_q;
    sum_q[8] <= p22_q;
  end

  logic signed [15:0] m_q [9];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 9; k++) begin
      m_q[k] <= emit(sum_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  assign valid_o = v_q[2];
  assign m_o     = m_q;

endmodule

// File: rtl/euler_angle_rotation_matrix.sv
// Channel   Handshake             Payload
// request   start_i / busy_o      angle_x_i, angle_y_i, angle_z_i (Q3.13)
// result    valid_o (one cycle)   m00_o .. m22_o (Q1.14, row order)
//
// One request per cycle; busy_o stays low. Each result passes through angle
// reduction, 30 CORDIC cells, and the multiply, round and saturate stages.
// Asynchronous active-low reset empties the pipeline. The receiver cannot
// stall; results are dropped if not taken.
module euler_angle_rotation_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] angle_x_i,
  input  logic signed [15:0] angle_y_i,
  input  logic signed [15:0] angle_z_i,
  output logic               valid_o,
  output logic signed [15:0] m00_o,
  output logic signed [15:0] m01_o,
  output logic signed [15:0] m02_o,
  output logic signed [15:0] m10_o,
  output logic signed [15:0] m11_o,
  output logic signed [15:0] m12_o,
  output logic signed [15:0] m20_o,
  output logic signed [15:0] m21_o,
  output logic signed [15:0] m22_o
);

  localparam int N = eul_pkg::STEPS;

  logic signed [15:0]   angle [3];
  logic                 v_chain [N+1];
  eul_pkg::lane_t [2:0] l_chain [N+1];
  logic signed [15:0]   m [9];

  assign busy_o   = 1'b0;
  assign angle[0] = angle_x_i;
  assign angle[1] = angle_y_i;
  assign angle[2] = angle_z_i;

  eul_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i & ~busy_o),
    .angle_i (angle),
    .valid_o (v_chain[0]),
    .lane_o  (l_chain[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    eul_cell #(.IDX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v_chain[i]),
      .lane_i  (l_chain[i]),
      .valid_o (v_chain[i+1]),
      .lane_o  (l_chain[i+1])
    );
  end

  eul_mat u_mat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_chain[N]),
    .lane_i  (l_chain[N]),
    .valid_o (valid_o),
    .m_o     (m)
  );

  assign m00_o = m[0];
  assign m01_o = m[1];
  assign m02_o = m[2];
  assign m10_o = m[3];
  assign m11_o = m[4];
  assign m12_o = m[5];
  assign m20_o = m[6];
  assign m21_o = m[7];
  assign m22_o = m[8];

`ifndef NO_ASSERTIONS
  a_valid_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, eul_pkg::LATENCY))
    else $error("result without request");

  a_m00_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (m00_o <= 16'(eul_pkg::OUT_LIM)) && (m00_o >= -16'(eul_pkg::OUT_LIM)))
    else $error("m00 out of range");

  a_m11_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (m11_o <= 16'(eul_pkg::OUT_LIM)) && (m11_o >= -16'(eul_pkg::OUT_LIM)))
    else $error("m11 out of range");
`endif

endmodule
